[hdl/accel_tilt_angle_core_macros.svh]
// assertion macros shared by the tilt angle core
// no dependencies, taken in by `include
`ifndef ACCEL_TILT_ANGLE_CORE_MACROS_SVH
`define ACCEL_TILT_ANGLE_CORE_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ATA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tilt angle check failed");

// antecedent holds, consequent holds in the next cycle
`define ATA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tilt angle check failed");

`endif

[hdl/ata_pkg.sv]
// types and constants of the tilt angle core
// no dependencies
`default_nettype none
package ata_pkg;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned TABLE_LEN  = 24;

   localparam logic [1:0] CSR_UNITS_MODE     = 2'd0;
   localparam logic [1:0] CSR_REFERENCE_AXIS = 2'd1;

   localparam logic signed [35:0] QUARTER_TURN = 36'sd1073741824;
   localparam logic signed [35:0] HALF_TURN    = 36'sd2147483648;

   localparam logic [31:0] DEG_SCALE = 32'd46080;
   localparam logic [31:0] RAD_SCALE = 32'd3373259426;
   localparam logic [15:0] DEG_FULL  = 16'd46080;
   localparam logic [15:0] RAD_FULL  = 16'd51472;

   typedef struct packed {
      logic valid;
      logic zero;
      logic neg;
   } flags_type;

   // arctangent of 2^-i in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/ata_sqrt_cell.sv]
// one digit step of the pipelined square root
// depends on ata_pkg
`default_nettype none
module ata_sqrt_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic [33:0]         rem_i,
   input  wire logic [31:0]         root_i,
   input  wire logic [31:0]         src_i,
   input  wire logic signed [32:0]  a_i,
   input  wire ata_pkg::flags_type  flags_i,
   output logic      [33:0]         rem_o,
   output logic      [31:0]         root_o,
   output logic      [31:0]         src_o,
   output logic signed [32:0]       a_o,
   output ata_pkg::flags_type       flags_o
);

   logic [35:0] cur;
   logic [35:0] trial;
   logic        take;
   logic [33:0] rem_in;
   logic [31:0] root_in;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [31:0] src_ff;
   logic signed [32:0] a_ff;
   ata_pkg::flags_type flags_ff;

   always_comb begin
      cur   = {rem_i, src_i[31:30]};
      trial = {2'b00, root_i, 2'b01};
      take  = (cur >= trial);
      if (take) begin
         rem_in  = 34'(cur - trial);
         root_in = {root_i[30:0], 1'b1};
      end else begin
         rem_in  = 34'(cur);
         root_in = {root_i[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (en) begin
         flags_ff <= flags_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         src_ff  <= {src_i[29:0], 2'b00};
         a_ff    <= a_i;
      end
   end

   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign src_o   = src_ff;
   assign a_o     = a_ff;
   assign flags_o = flags_ff;

endmodule
`default_nettype wire

[hdl/ata_cordic_cell.sv]
// one vectoring rotation of the pipelined cordic
// depends on ata_pkg
`default_nettype none
module ata_cordic_cell #(
   parameter int IDX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic signed [35:0]  x_i,
   input  wire logic signed [35:0]  y_i,
   input  wire logic signed [35:0]  z_i,
   input  wire ata_pkg::flags_type  flags_i,
   output logic signed [35:0]       x_o,
   output logic signed [35:0]       y_o,
   output logic signed [35:0]       z_o,
   output ata_pkg::flags_type       flags_o
);

   localparam logic signed [35:0] ATAN = $signed({4'b0000, ata_pkg::atan_turn(IDX)});

   logic signed [35:0] xs;
   logic signed [35:0] ys;
   logic signed [35:0] x_in;
   logic signed [35:0] y_in;
   logic signed [35:0] z_in;
   logic signed [35:0] x_ff;
   logic signed [35:0] y_ff;
   logic signed [35:0] z_ff;
   ata_pkg::flags_type flags_ff;

   always_comb begin
      xs = x_i >>> IDX;
      ys = y_i >>> IDX;
      if (y_i > 36'sd0) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ATAN;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (en) begin
         flags_ff <= flags_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign flags_o = flags_ff;

endmodule
`default_nettype wire

[hdl/accel_tilt_angle_core.sv]
// top level of the accelerometer tilt angle core
// depends on ata_pkg, ata_sqrt_cell, ata_cordic_cell, accel_tilt_angle_core_macros.svh
//
// usage
//  - req_ channel carries one sample word (accel_x, accel_y, accel_z), taken at a
//    clock edge with req_valid high and req_stall low
//  - rsp_ channel returns one word per sample, in order: angle and zero_vector,
//    taken at an edge with rsp_valid high and rsp_stall low
//  - csr_ channel writes units_mode (index 0) or reference_axis (index 1), always
//    ready; write only while no sample is in flight
//  - the chain is input register, square, sum, 32 square-root digit cells, one cell per
//    cordic stage (at most 24), clamp, scale multiply and output register
//  - throughput is one sample per cycle while no result is stalled; every cell hands
//    its word on each cycle that the chain advances
//  - a stalled result freezes the whole chain and holds req_stall high until
//    the result is taken, so nothing is lost or repeated
//  - synchronous reset empties the chain and clears both registers to zero
`default_nettype none
`include "accel_tilt_angle_core_macros.svh"
module accel_tilt_angle_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // sample input
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   // result output
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [15:0]             rsp_angle,
   output logic                    rsp_zero_vector,
   // register writes
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic               csr_wdata
);

   localparam int NSTG = (CORDIC_STAGES < ata_pkg::TABLE_LEN) ?
                         CORDIC_STAGES : ata_pkg::TABLE_LEN;
   localparam int NSQ  = ata_pkg::SQRT_STEPS;

   // whole chain advances unless a finished word is held back
   logic pipe_en;
   logic rsp_valid_ff;
   assign pipe_en   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en;
   assign csr_ready = 1'b1;

   // configuration
   logic units_ff;
   logic axis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff <= 1'b0;
         axis_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ata_pkg::CSR_UNITS_MODE:     units_ff <= csr_wdata;
            ata_pkg::CSR_REFERENCE_AXIS: axis_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 0: pick reference and in-plane components
   logic signed [32:0] a_in;
   logic signed [15:0] p_in;
   ata_pkg::flags_type f0_in;
   logic signed [32:0] a0_ff;
   logic signed [15:0] p0_ff;
   logic signed [15:0] z0_ff;
   ata_pkg::flags_type f0_ff;

   always_comb begin
      f0_in.valid = req_valid && !req_stall;
      f0_in.zero  = (req_accel_x == 16'sd0) && (req_accel_y == 16'sd0) &&
                    (req_accel_z == 16'sd0);
      if (!axis_ff) begin
         a_in      = -($signed({{17{req_accel_x[15]}}, req_accel_x}) <<< 16);
         p_in      = req_accel_y;
         f0_in.neg = req_accel_y[15];
      end else begin
         a_in      = $signed({{17{req_accel_y[15]}}, req_accel_y}) <<< 16;
         p_in      = req_accel_x;
         f0_in.neg = !req_accel_x[15];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_ff <= '0;
      end else if (pipe_en) begin
         f0_ff <= f0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a0_ff <= a_in;
         p0_ff <= p_in;
         z0_ff <= req_accel_z;
      end
   end

   // stage 1: squares
   logic signed [31:0] pp_s;
   logic signed [31:0] zz_s;
   logic [31:0]        pp1_ff;
   logic [31:0]        zz1_ff;
   logic signed [32:0] a1_ff;
   ata_pkg::flags_type f1_ff;

   assign pp_s = p0_ff * p0_ff;
   assign zz_s = z0_ff * z0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= '0;
      end else if (pipe_en) begin
         f1_ff <= f0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pp1_ff <= unsigned'(pp_s);
         zz1_ff <= unsigned'(zz_s);
         a1_ff  <= a0_ff;
      end
   end

   // stage 2: sum of squares, at most 2^31
   logic [31:0]        sq2_ff;
   logic signed [32:0] a2_ff;
   ata_pkg::flags_type f2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_ff <= '0;
      end else if (pipe_en) begin
         f2_ff <= f1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq2_ff <= pp1_ff + zz1_ff;
         a2_ff  <= a1_ff;
      end
   end

   // square root of sum * 2^32, one result bit per cell
   logic [33:0]        rem_w   [0:NSQ];
   logic [31:0]        root_w  [0:NSQ];
   logic [31:0]        src_w   [0:NSQ];
   logic signed [32:0] sa_w    [0:NSQ];
   ata_pkg::flags_type sf_w    [0:NSQ];

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign src_w[0]  = sq2_ff;
   assign sa_w[0]   = a2_ff;
   assign sf_w[0]   = f2_ff;

   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      ata_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .rem_i   (rem_w[g]),
         .root_i  (root_w[g]),
         .src_i   (src_w[g]),
         .a_i     (sa_w[g]),
         .flags_i (sf_w[g]),
         .rem_o   (rem_w[g+1]),
         .root_o  (root_w[g+1]),
         .src_o   (src_w[g+1]),
         .a_o     (sa_w[g+1]),
         .flags_o (sf_w[g+1])
      );
   end

   // cordic entry: quarter-turn pre-rotation when the reference part is negative
   logic signed [35:0] cx_w [0:NSTG];
   logic signed [35:0] cy_w [0:NSTG];
   logic signed [35:0] cz_w [0:NSTG];
   ata_pkg::flags_type cf_w [0:NSTG];
   logic signed [35:0] a_ext;
   logic signed [35:0] b_ext;
   logic signed [35:0] cx0;
   logic signed [35:0] cy0;
   logic signed [35:0] cz0;

   assign a_ext = 36'(sa_w[NSQ]);
   assign b_ext = $signed({4'b0000, root_w[NSQ]});

   always_comb begin
      if (a_ext < 36'sd0) begin
         cx0 = b_ext;
         cy0 = -a_ext;
         cz0 = ata_pkg::QUARTER_TURN;
      end else begin
         cx0 = a_ext;
         cy0 = b_ext;
         cz0 = 36'sd0;
      end
   end
   assign cx_w[0] = cx0;
   assign cy_w[0] = cy0;
   assign cz_w[0] = cz0;
   assign cf_w[0] = sf_w[NSQ];

   for (genvar g = 0; g < NSTG; g++) begin : g_cordic
      ata_cordic_cell #(.IDX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .x_i     (cx_w[g]),
         .y_i     (cy_w[g]),
         .z_i     (cz_w[g]),
         .flags_i (cf_w[g]),
         .x_o     (cx_w[g+1]),
         .y_o     (cy_w[g+1]),
         .z_o     (cz_w[g+1]),
         .flags_o (cf_w[g+1])
      );
   end

   // clamp to [0, half turn] and apply the sign rule, giving a turn fraction
   logic signed [35:0] zc;
   logic [31:0]        t_in;
   logic [31:0]        t_ff;
   logic [31:0]        k_ff;
   ata_pkg::flags_type ft_ff;

   always_comb begin
      zc = cz_w[NSTG];
      if (zc < 36'sd0) begin
         zc = 36'sd0;
      end else if (zc > ata_pkg::HALF_TURN) begin
         zc = ata_pkg::HALF_TURN;
      end
      t_in = cf_w[NSTG].neg ? 32'(-zc) : zc[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ft_ff <= '0;
      end else if (pipe_en) begin
         ft_ff <= cf_w[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t_ff <= t_in;
         k_ff <= units_ff ? ata_pkg::DEG_SCALE : ata_pkg::RAD_SCALE;
      end
   end

   // scale multiply
   logic [63:0]        prod_in;
   logic [63:0]        prod_ff;
   logic               unit_m_ff;
   ata_pkg::flags_type fm_ff;

   assign prod_in = t_ff * k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fm_ff <= '0;
      end else if (pipe_en) begin
         fm_ff <= ft_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         prod_ff   <= prod_in;
         unit_m_ff <= units_ff;
      end
   end

   // rounding, full-turn wrap and output register
   logic [64:0] rnd_deg;
   logic [64:0] rnd_rad;
   logic [15:0] ang_in;
   logic [15:0] angle_ff;
   logic        zero_ff;

   always_comb begin
      rnd_deg = {1'b0, prod_ff} + 65'h0_8000_0000;
      rnd_rad = {1'b0, prod_ff} + 65'h0_8000_0000_0000;
      if (unit_m_ff) begin
         ang_in = (rnd_deg[64:32] >= 33'(ata_pkg::DEG_FULL)) ? 16'd0 : rnd_deg[47:32];
      end else begin
         ang_in = (rnd_rad[64:48] >= 17'(ata_pkg::RAD_FULL)) ? 16'd0 : rnd_rad[63:48];
      end
      if (fm_ff.zero) begin
         ang_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= fm_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         angle_ff <= ang_in;
         zero_ff  <= fm_ff.zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle       = angle_ff;
   assign rsp_zero_vector = zero_ff;

   // checks
   `ATA_ASSERT_SAME(a_zero_angle, clock, reset, rsp_valid && rsp_zero_vector, rsp_angle == 16'd0)
   `ATA_ASSERT_SAME(a_rad_range, clock, reset, rsp_valid && !units_ff, rsp_angle < ata_pkg::RAD_FULL)
   `ATA_ASSERT_NEXT(a_chain_hold, clock, reset, !pipe_en, $stable(fm_ff) && $stable(ft_ff))

endmodule
`default_nettype wire
